// File: sv/rlbd_pkg.sv
// Shared types, widths, register indexes and reset values for the
// resistor-ladder button decoder. No dependencies.
package rlbd_pkg;

	localparam int MAX_BUTTONS_DEF = 8;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int CODE_W   = 4;
	localparam int TIME_W   = 32;
	localparam int MS_W     = 16;
	localparam int GROUP_W  = 64;
	localparam int BOUNDS_W = 2 * GROUP_W;
	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 64;

	localparam int QUEUE_DEPTH = 2;
	// quotient bits of the repeat divider: dividend stays below 2^32 + repeat/2
	localparam int DIV_STEPS = TIME_W + 1;

	typedef enum logic [2:0] {
		REG_BUTTON_COUNT = 3'd0,
		REG_DEBOUNCE     = 3'd1,
		REG_HOLD         = 3'd2,
		REG_REPEAT       = 3'd3,
		REG_BOUND_LO     = 3'd4,
		REG_BOUND_HI     = 3'd5
	} reg_idx_t;

	localparam logic [CODE_W-1:0] BUTTON_COUNT_RST = 4'd0;
	localparam logic [MS_W-1:0]   DEBOUNCE_RST     = 16'd50;
	localparam logic [MS_W-1:0]   HOLD_RST         = 16'd500;
	localparam logic [MS_W-1:0]   REPEAT_RST       = 16'd100;

	localparam logic [CODE_W-1:0] CODE_NONE = '0;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [TIME_W-1:0] ms_stamp_t;

	typedef struct packed {
		code_t               button_count;
		logic [MS_W-1:0]     debounce_ms;
		logic [MS_W-1:0]     hold_ms;
		logic [MS_W-1:0]     repeat_ms;
		logic [BOUNDS_W-1:0] bounds;
	} cfg_t;

	// front-end result for one item, finished by the back end
	typedef struct packed {
		code_t     pressed;
		code_t     press_ev;
		code_t     rel_ev;
		ms_stamp_t elapsed;
		ms_stamp_t rel_hold;
		logic      hold_flag;
		ms_stamp_t hold_mark;
		ms_stamp_t stamp;
		ms_stamp_t step;
	} job_t;

endpackage

// File: sv/rlbd_if.sv
// Item channels of the button decoder: sample input and event output.
// Depends on rlbd_pkg.
interface rlbd_in_if import rlbd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic [TIME_W-1:0]      timestamp_ms;

	modport source (output valid, output sample, output timestamp_ms, input ready);
	modport sink (input valid, input sample, input timestamp_ms, output ready);
endinterface

interface rlbd_out_if import rlbd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] pressed_code;
	logic [CODE_W-1:0] press_event_code;
	logic [CODE_W-1:0] release_event_code;
	logic [TIME_W-1:0] press_elapsed_ms;
	logic [TIME_W-1:0] released_hold_ms;
	logic              hold_event;
	logic              repeat_event;

	modport source (output valid, output pressed_code, output press_event_code,
		output release_event_code, output press_elapsed_ms, output released_hold_ms,
		output hold_event, output repeat_event, input ready);
	modport sink (input valid, input pressed_code, input press_event_code,
		input release_event_code, input press_elapsed_ms, input released_hold_ms,
		input hold_event, input repeat_event, output ready);
endinterface

// File: sv/rlbd_front.sv
// Front end: decodes each sample to a button code, runs debounce and press
// tracking, and pushes a job to the queue. Depends on rlbd_pkg, rlbd_if.
module rlbd_front import rlbd_pkg::*; #(
	parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	rlbd_in_if.sink samples,
	output job_t    job,
	output logic    push,
	input  logic    full
);

	logic [SAMPLE_BITS-1:0] samp;
	logic [MS_W-1:0]        samp_ext;
	code_t                  n_eff;
	code_t                  cand_d;
	logic                   found;

	logic      v_s1;
	code_t     cand_s1;
	ms_stamp_t ts_s1;

	ms_stamp_t cur_q, dstart_q, pstart_q, relstart_q;
	code_t     dcand_q, pressed_q;

	ms_stamp_t dstart_n, pstart_n, relstart_n, hold_mark;
	code_t     pressed_n;
	logic      fire;

	assign samp     = samples.sample;
	assign samp_ext = MS_W'(samp);
	assign n_eff    = (32'(cfg.button_count) > MAX_BUTTONS) ? CODE_W'(MAX_BUTTONS)
		: cfg.button_count;

	// lowest button whose upper boundary lies above the sample
	always_comb begin
		cand_d = CODE_NONE;
		found  = 1'b0;
		for (int k = 0; k < MAX_BUTTONS; k++) begin
			if (!found && (CODE_W'(k) < n_eff) && (samp_ext < cfg.bounds[k*MS_W +: MS_W])) begin
				cand_d = CODE_W'(k + 1);
				found  = 1'b1;
			end
		end
	end

	assign push          = v_s1 && !full;
	assign samples.ready = !v_s1 || !full;

	always_comb begin
		dstart_n   = (cand_s1 != dcand_q) ? ts_s1 : dstart_q;
		fire       = ((ts_s1 - dstart_n) > TIME_W'(cfg.debounce_ms)) && (cand_s1 != pressed_q);
		pressed_n  = fire ? cand_s1 : pressed_q;
		pstart_n   = (fire && cand_s1 != CODE_NONE) ? ts_s1 : pstart_q;
		relstart_n = fire ? pstart_q : relstart_q;
		hold_mark  = pstart_n + TIME_W'(cfg.hold_ms);

		job.pressed   = pressed_n;
		job.press_ev  = fire ? cand_s1 : CODE_NONE;
		job.rel_ev    = fire ? pressed_q : CODE_NONE;
		job.rel_hold  = (fire && pressed_q != CODE_NONE) ? (ts_s1 - relstart_n) : '0;
		job.elapsed   = (pressed_n != CODE_NONE) ? (ts_s1 - pstart_n) : '0;
		job.step      = ts_s1 - cur_q;
		job.hold_flag = (pressed_n != CODE_NONE) && ((ts_s1 - hold_mark) < job.step);
		job.hold_mark = hold_mark;
		job.stamp     = ts_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			cand_s1    <= CODE_NONE;
			ts_s1      <= '0;
			cur_q      <= '0;
			dcand_q    <= CODE_NONE;
			dstart_q   <= '0;
			pressed_q  <= CODE_NONE;
			pstart_q   <= '0;
			relstart_q <= '0;
		end else begin
			// hold the stage until pushed, refill on a new item
			v_s1 <= (samples.valid && samples.ready) || (v_s1 && !push);
			if (push) begin
				cur_q      <= ts_s1;
				dcand_q    <= cand_s1;
				dstart_q   <= dstart_n;
				pressed_q  <= pressed_n;
				pstart_q   <= pstart_n;
				relstart_q <= relstart_n;
			end
			if (samples.valid && samples.ready) begin
				cand_s1 <= cand_d;
				ts_s1   <= samples.timestamp_ms;
			end
		end
	end

endmodule

// File: sv/rlbd_queue.sv
// Short job queue between front and back end.
// Depends on rlbd_pkg.
module rlbd_queue import rlbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output job_t rd_job,
	output logic nonempty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: sv/rlbd_back.sv
// Back end: finds the repeat count with a bit-serial divider, forms the
// repeat mark and drives the output register. Depends on rlbd_pkg, rlbd_if.
module rlbd_back import rlbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  job_t       rd_job,
	input  logic       nonempty,
	output logic       pop,
	rlbd_out_if.source events
);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_FIN} state_t;

	localparam int CNT_W = $clog2(DIV_STEPS + 1);
	localparam int N_W   = TIME_W + 2;

	state_t               state_q;
	job_t                 job_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [MS_W-1:0]      rem_q;
	logic [CNT_W-1:0]     cnt_q;
	ms_stamp_t            prod_q;

	logic [N_W-1:0]  n_val;
	logic            n_pos;
	logic [MS_W:0]   rem_sh, rem_sub;
	logic            ge;
	ms_stamp_t       rep_mark;
	logic            rep_flag;
	logic            out_free;
	logic            emit;

	// n = elapsed - hold + repeat/2, kept signed in N_W bits
	assign n_val = N_W'(rd_job.elapsed) - N_W'(cfg.hold_ms) + N_W'(cfg.repeat_ms[MS_W-1:1]);
	assign n_pos = !n_val[N_W-1] && (n_val != '0);

	assign rem_sh  = {rem_q, quo_q[DIV_STEPS-1]};
	assign rem_sub = rem_sh - {1'b0, cfg.repeat_ms};
	assign ge      = (rem_sh >= {1'b0, cfg.repeat_ms});

	assign rep_mark = job_q.hold_mark + prod_q;
	assign rep_flag = (job_q.pressed != CODE_NONE) && ((job_q.stamp - rep_mark) < job_q.step);

	assign out_free = !events.valid || events.ready;
	assign emit     = (state_q == S_FIN) && out_free;
	assign pop      = (state_q == S_IDLE) && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q                   <= S_IDLE;
			job_q                     <= '0;
			quo_q                     <= '0;
			rem_q                     <= '0;
			cnt_q                     <= '0;
			prod_q                    <= '0;
			events.valid              <= 1'b0;
			events.pressed_code       <= CODE_NONE;
			events.press_event_code   <= CODE_NONE;
			events.release_event_code <= CODE_NONE;
			events.press_elapsed_ms   <= '0;
			events.released_hold_ms   <= '0;
			events.hold_event         <= 1'b0;
			events.repeat_event       <= 1'b0;
		end else begin
			if (events.valid && events.ready && !emit) begin
				events.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (nonempty) begin
						job_q <= rd_job;
						rem_q <= '0;
						cnt_q <= CNT_W'(DIV_STEPS);
						if ((rd_job.pressed != CODE_NONE) && (cfg.repeat_ms != '0) && n_pos) begin
							quo_q   <= n_val[DIV_STEPS-1:0];
							state_q <= S_DIV;
						end else begin
							// no repeat step counted: the mark sits on the hold mark
							quo_q   <= '0;
							state_q <= S_MUL;
						end
					end
				end
				S_DIV: begin
					rem_q <= ge ? rem_sub[MS_W-1:0] : rem_sh[MS_W-1:0];
					quo_q <= {quo_q[DIV_STEPS-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					// only the low bits matter, the mark wraps at 2^32
					prod_q  <= TIME_W'(cfg.repeat_ms * quo_q[TIME_W-1:0]);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						events.valid              <= 1'b1;
						events.pressed_code       <= job_q.pressed;
						events.press_event_code   <= job_q.press_ev;
						events.release_event_code <= job_q.rel_ev;
						events.press_elapsed_ms   <= job_q.elapsed;
						events.released_hold_ms   <= job_q.rel_hold;
						events.hold_event         <= job_q.hold_flag;
						events.repeat_event       <= rep_flag;
						state_q                   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sv/resistor_ladder_button_decoder.sv
// Resistor-ladder keypad decoder: each sample item is decoded to a button,
// debounced, and answered by one event item carrying the pressed button, press
// and release events, press timing and hold / auto-repeat flags. An item whose
// button is pressed, with a nonzero repeat period and a positive repeat offset, passes
// through the one-bit-per-cycle repeat divider (33 steps) in the back end; other items
// skip it. The front end can accept a new item as it pushes the last and, with the
// two-entry job queue, runs up to three items ahead of the back end, which takes no new
// item until the last one is in the output register. Registers sit on an APB port,
// 64-bit data, register i at byte address 8*i; write them only while idle.
// Depends on rlbd_pkg, rlbd_if, rlbd_front, rlbd_queue, rlbd_back.
module resistor_ladder_button_decoder import rlbd_pkg::*; #(
	parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rlbd_in_if.sink           samples,
	rlbd_out_if.source        events,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	job_t push_job, rd_job;
	logic push, full, pop, nonempty;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.button_count <= BUTTON_COUNT_RST;
			cfg_q.debounce_ms  <= DEBOUNCE_RST;
			cfg_q.hold_ms      <= HOLD_RST;
			cfg_q.repeat_ms    <= REPEAT_RST;
			cfg_q.bounds       <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_BUTTON_COUNT: cfg_q.button_count <= pwdata[CODE_W-1:0];
				REG_DEBOUNCE:     cfg_q.debounce_ms  <= pwdata[MS_W-1:0];
				REG_HOLD:         cfg_q.hold_ms      <= pwdata[MS_W-1:0];
				REG_REPEAT:       cfg_q.repeat_ms    <= pwdata[MS_W-1:0];
				REG_BOUND_LO:     cfg_q.bounds[GROUP_W-1:0] <= pwdata[GROUP_W-1:0];
				REG_BOUND_HI:     cfg_q.bounds[BOUNDS_W-1:GROUP_W] <= pwdata[GROUP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BUTTON_COUNT: prdata = DATA_W'(cfg_q.button_count);
			REG_DEBOUNCE:     prdata = DATA_W'(cfg_q.debounce_ms);
			REG_HOLD:         prdata = DATA_W'(cfg_q.hold_ms);
			REG_REPEAT:       prdata = DATA_W'(cfg_q.repeat_ms);
			REG_BOUND_LO:     prdata = DATA_W'(cfg_q.bounds[GROUP_W-1:0]);
			REG_BOUND_HI:     prdata = DATA_W'(cfg_q.bounds[BOUNDS_W-1:GROUP_W]);
			default:          prdata = '0;
		endcase
	end

	rlbd_front #(
		.MAX_BUTTONS(MAX_BUTTONS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.samples(samples),
		.job    (push_job),
		.push   (push),
		.full   (full)
	);

	rlbd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_job  (push_job),
		.full    (full),
		.pop     (pop),
		.rd_job  (rd_job),
		.nonempty(nonempty)
	);

	rlbd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.rd_job  (rd_job),
		.nonempty(nonempty),
		.pop     (pop),
		.events  (events)
	);

endmodule

// File: sv/rlbd_checker.sv
// Port-level checks of event consistency for the button decoder, bound to
// the top level. Depends on rlbd_pkg.
module rlbd_checker import rlbd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CODE_W-1:0] pressed,
	input logic [CODE_W-1:0] press_ev,
	input logic [CODE_W-1:0] rel_ev,
	input logic [TIME_W-1:0] elapsed,
	input logic [TIME_W-1:0] rel_hold,
	input logic              hold_ev,
	input logic              rep_ev
);

	logic              acc;
	logic [CODE_W-1:0] last_q;

	assign acc = out_valid && out_ready;

	// track the pressed button as last delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= CODE_NONE;
		end else if (acc) begin
			last_q <= pressed;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressed) && $stable(elapsed))
		else $error("event item changed while stalled");

	a_press_is_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		acc && press_ev != CODE_NONE |-> pressed == press_ev)
		else $error("press event differs from pressed button");

	a_release_continuity: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ((press_ev == CODE_NONE && rel_ev == CODE_NONE) ? (pressed == last_q)
			: (rel_ev == last_q)))
		else $error("pressed button changed without matching events");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pressed == CODE_NONE |-> elapsed == '0 && !hold_ev && !rep_ev)
		else $error("timing reported with no button pressed");

	a_release_hold_zero: assert property (@(posedge clk) disable iff (!arst_n)
		acc && rel_ev == CODE_NONE |-> rel_hold == '0)
		else $error("release hold time without release");

endmodule

bind resistor_ladder_button_decoder rlbd_checker u_rlbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(events.valid),
	.out_ready(events.ready),
	.pressed  (events.pressed_code),
	.press_ev (events.press_event_code),
	.rel_ev   (events.release_event_code),
	.elapsed  (events.press_elapsed_ms),
	.rel_hold (events.released_hold_ms),
	.hold_ev  (events.hold_event),
	.rep_ev   (events.repeat_event)
);
